// ----- rtl/nsd_pkg.sv -----
package nsd_pkg;

    localparam int DIM_BITS_DEFAULT = 16;
    localparam int ACC_W            = 24;
    localparam int S_TDATA_W        = 8;
    localparam int S_TUSER_W        = 2;
    localparam int M_TDATA_W        = 104;
    localparam int M_TUSER_W        = 2;

    localparam logic [ACC_W-1:0] ACC_MAX = 24'hFFFFFF;
    localparam logic [15:0]      MAXV_8  = 16'd255;
    localparam logic [15:0]      MAXV_16 = 16'hFFFF;

    // actions on the input tuser
    localparam logic [1:0] ACT_DATA    = 2'd0;
    localparam logic [1:0] ACT_EOF     = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // result kinds on the output tuser
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_HEADER = 2'd1;
    localparam logic [1:0] ERR_SHORT  = 2'd2;
    localparam logic [1:0] ERR_BITMAP = 2'd3;

    localparam logic [2:0] FMT_P1 = 3'd1;
    localparam logic [2:0] FMT_P2 = 3'd2;
    localparam logic [2:0] FMT_P3 = 3'd3;
    localparam logic [2:0] FMT_P4 = 3'd4;
    localparam logic [2:0] FMT_P5 = 3'd5;
    localparam logic [2:0] FMT_P6 = 3'd6;

    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_6    = 8'h36;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SP   = 8'h20;

    typedef enum logic [2:0] {
        PH_MAGIC0,
        PH_MAGIC1,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXVAL,
        PH_PIXELS,
        PH_HALT
    } phase_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_EXEC,
        CS_MUL,
        CS_CMP,
        CS_ITER,
        CS_DONE,
        CS_EOF,
        CS_BITS
    } ctl_state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic div_mul;
        logic div_cmp;
        logic div_iter;
        logic div_done;
        logic eof_err;
        logic bit_emit;
    } nsd_cmd_t;

    typedef struct packed {
        logic out_free;
        logic go_div;
        logic go_bits;
        logic div_last;
        logic eof_go;
        logic bits_last;
    } nsd_status_t;

endpackage

// ----- rtl/nsd_ctrl.sv -----
module nsd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  nsd_pkg::nsd_status_t status,
    output nsd_pkg::nsd_cmd_t    cmd
);
    import nsd_pkg::*;

    ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            CS_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC: begin
                if (status.out_free) begin
                    cmd.exec = 1'b1;
                    if (status.go_div) begin
                        state_next = CS_MUL;
                    end else if (status.go_bits) begin
                        state_next = CS_BITS;
                    end else begin
                        state_next = CS_IDLE;
                    end
                end
            end
            CS_MUL: begin
                cmd.div_mul = 1'b1;
                state_next  = CS_CMP;
            end
            CS_CMP: begin
                cmd.div_cmp = 1'b1;
                state_next  = CS_ITER;
            end
            CS_ITER: begin
                cmd.div_iter = 1'b1;
                if (status.div_last) begin
                    state_next = CS_DONE;
                end
            end
            CS_DONE: begin
                if (status.out_free) begin
                    cmd.div_done = 1'b1;
                    state_next   = status.eof_go ? CS_EOF : CS_IDLE;
                end
            end
            CS_EOF: begin
                if (status.out_free) begin
                    cmd.eof_err = 1'b1;
                    state_next  = CS_IDLE;
                end
            end
            CS_BITS: begin
                if (status.out_free) begin
                    cmd.bit_emit = 1'b1;
                    if (status.bits_last) begin
                        state_next = CS_IDLE;
                    end
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/nsd_datapath.sv -----
module nsd_datapath #(
    parameter int DIM_BITS = nsd_pkg::DIM_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [nsd_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [nsd_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [nsd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [nsd_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                           m_tlast,
    input  nsd_pkg::nsd_cmd_t              cmd,
    output nsd_pkg::nsd_status_t           status
);
    import nsd_pkg::*;

    localparam int DW = DIM_BITS;
    localparam logic [ACC_W:0] DIM_MAX = ((ACC_W+1)'(1) << DIM_BITS) - (ACC_W+1)'(1);

    // parser state
    logic [1:0]       act_reg, act_next;
    logic [7:0]       byte_reg, byte_next;
    phase_t           phase_reg, phase_next;
    logic [2:0]       fmt_reg, fmt_next;
    logic [DW-1:0]    width_reg, width_next;
    logic             wbad_reg, wbad_next;
    logic [DW-1:0]    height_reg, height_next;
    logic [15:0]      maxs_reg, maxs_next;
    logic [DW-1:0]    col_reg, col_next;
    logic [DW-1:0]    row_reg, row_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             innum_reg, innum_next;
    logic             incom_reg, incom_next;
    logic [1:0]       comp_reg, comp_next;
    logic [15:0]      hred_reg, hred_next;
    logic [15:0]      hgrn_reg, hgrn_next;
    logic [7:0]       hhi_reg, hhi_next;
    logic             bph_reg, bph_next;
    logic             eofp_reg, eofp_next;
    logic [2:0]       bitk_reg, bitk_next;
    // divider
    logic [ACC_W-1:0] divv_reg, divv_next;
    logic [31:0]      divd_reg, divd_next;
    logic [15:0]      divr_reg, divr_next;
    logic [7:0]       divq_reg, divq_next;
    logic [2:0]       divk_reg, divk_next;
    logic             dsat_reg, dsat_next;
    // output register
    logic             ovld_reg, ovld_next;
    logic [1:0]       okind_reg, okind_next;
    logic [2:0]       ofmt_reg, ofmt_next;
    logic [15:0]      ow_reg, ow_next, oh_reg, oh_next, om_reg, om_next;
    logic [15:0]      or_reg, or_next, og_reg, og_next, ob_reg, ob_next;
    logic [1:0]       oerr_reg, oerr_next;
    logic             olast_reg, olast_next;

    logic [DW:0]      col_inc, row_inc;
    logic             fin;
    logic             out_free;

    // working signals
    logic             do_pix, do_err, do_hdr, do_comp, num_done;
    logic [15:0]      pr, pg, pb, comp_v;
    logic [1:0]       err_code;
    logic [ACC_W-1:0] num_v;
    logic [7:0]       c;
    logic [27:0]      mul10;
    logic [16:0]      trial;
    logic [7:0]       lowb;
    logic [7:0]       sval;
    logic             done_pix;

    assign out_free = !ovld_reg || m_tready;
    assign col_inc  = {1'b0, col_reg} + (DW+1)'(1);
    assign row_inc  = {1'b0, row_reg} + (DW+1)'(1);
    assign fin      = (row_inc >= {1'b0, height_reg}) && (col_inc >= {1'b0, width_reg});
    assign c        = byte_reg;
    assign lowb     = divd_reg[7:0];
    assign trial    = {divr_reg, lowb[divk_reg]};
    assign sval     = dsat_reg ? 8'hFF : divq_reg;
    assign done_pix = (fmt_reg == FMT_P2) || (comp_reg == 2'd2);

    always_comb begin
        act_next = act_reg;   byte_next = byte_reg;   phase_next = phase_reg;
        fmt_next = fmt_reg;   width_next = width_reg; wbad_next = wbad_reg;
        height_next = height_reg; maxs_next = maxs_reg;
        col_next = col_reg;   row_next = row_reg;     acc_next = acc_reg;
        innum_next = innum_reg; incom_next = incom_reg; comp_next = comp_reg;
        hred_next = hred_reg; hgrn_next = hgrn_reg;   hhi_next = hhi_reg;
        bph_next = bph_reg;   eofp_next = eofp_reg;   bitk_next = bitk_reg;
        divv_next = divv_reg; divd_next = divd_reg;   divr_next = divr_reg;
        divq_next = divq_reg; divk_next = divk_reg;   dsat_next = dsat_reg;
        ovld_next = ovld_reg && !m_tready;
        okind_next = okind_reg; ofmt_next = ofmt_reg; ow_next = ow_reg;
        oh_next = oh_reg; om_next = om_reg; or_next = or_reg; og_next = og_reg;
        ob_next = ob_reg; oerr_next = oerr_reg; olast_next = olast_reg;

        status          = '0;
        status.out_free = out_free;
        status.div_last = (divk_reg == 3'd0);
        status.eof_go   = eofp_reg && !(done_pix && fin);
        status.bits_last = (col_inc >= {1'b0, width_reg}) || (bitk_reg == 3'd7);

        do_pix = 1'b0; do_err = 1'b0; do_hdr = 1'b0; do_comp = 1'b0; num_done = 1'b0;
        pr = '0; pg = '0; pb = '0; comp_v = '0; err_code = ERR_NONE; num_v = '0;
        mul10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + 28'(c - CH_0);

        if (cmd.load) begin
            act_next  = s_tuser;
            byte_next = s_tdata;
            bitk_next = '0;
        end

        if (cmd.exec) begin
            if (act_reg == ACT_RESTART) begin
                phase_next = PH_MAGIC0; fmt_next = '0; width_next = '0; wbad_next = 1'b0;
                height_next = '0; maxs_next = '0; col_next = '0; row_next = '0;
                acc_next = '0; innum_next = 1'b0; incom_next = 1'b0; comp_next = '0;
                hred_next = '0; hgrn_next = '0; hhi_next = '0; bph_next = 1'b0;
                eofp_next = 1'b0;
            end else if (act_reg == ACT_EOF && phase_reg != PH_HALT) begin
                if (phase_reg != PH_PIXELS) begin
                    do_err = 1'b1; err_code = ERR_HEADER;
                end else if ((fmt_reg == FMT_P2 || fmt_reg == FMT_P3) && innum_reg) begin
                    // pending sample finishes first; a short-image error follows unless it completes the image
                    innum_next = 1'b0; incom_next = 1'b0; acc_next = '0;
                    divv_next = acc_reg; eofp_next = 1'b1; status.go_div = 1'b1;
                end else begin
                    do_err = 1'b1; err_code = ERR_SHORT;
                end
            end else if (act_reg == ACT_DATA && phase_reg != PH_HALT) begin
                if (phase_reg == PH_MAGIC0) begin
                    if (c != CH_P) begin
                        do_err = 1'b1; err_code = ERR_HEADER;
                    end else begin
                        phase_next = PH_MAGIC1;
                    end
                end else if (phase_reg == PH_MAGIC1) begin
                    if (c < CH_1 || c > CH_6) begin
                        do_err = 1'b1; err_code = ERR_HEADER;
                    end else begin
                        fmt_next   = 3'(c - CH_0);
                        phase_next = PH_WIDTH;
                    end
                end else if (!(incom_reg && c != CH_NL)) begin
                    incom_next = 1'b0;
                    if (phase_reg != PH_PIXELS || fmt_reg == FMT_P2 || fmt_reg == FMT_P3) begin
                        if (c >= CH_0 && c <= CH_9) begin
                            acc_next   = (mul10 > {4'b0, ACC_MAX}) ? ACC_MAX : mul10[ACC_W-1:0];
                            innum_next = 1'b1;
                        end else if (c == CH_HASH) begin
                            incom_next = 1'b1;
                        end else if (innum_reg) begin
                            innum_next = 1'b0;
                            acc_next   = '0;
                            num_done   = 1'b1;
                            num_v      = acc_reg;
                        end
                    end else if (fmt_reg == FMT_P1) begin
                        if (c == CH_HASH) begin
                            incom_next = 1'b1;
                        end else if (c == CH_0 || c == CH_1) begin
                            do_pix = 1'b1;
                            pr = {15'b0, c[0]}; pg = pr; pb = pr;
                        end else if (!(c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_NL)) begin
                            do_err = 1'b1; err_code = ERR_BITMAP;
                        end
                    end else if (fmt_reg == FMT_P4) begin
                        status.go_bits = 1'b1;
                    end else begin
                        if (maxs_reg == MAXV_8) begin
                            comp_v = {8'b0, c};
                        end else if (!bph_reg) begin
                            hhi_next = c;
                            bph_next = 1'b1;
                        end else begin
                            bph_next = 1'b0;
                            comp_v   = {hhi_reg, c};
                        end
                        if (maxs_reg == MAXV_8 || bph_reg) begin
                            if (fmt_reg == FMT_P5) begin
                                do_pix = 1'b1; pr = comp_v; pg = comp_v; pb = comp_v;
                            end else begin
                                do_comp = 1'b1;
                            end
                        end
                    end
                end
            end
        end

        if (num_done) begin
            unique case (phase_reg)
                PH_WIDTH: begin
                    width_next = DW'(num_v);
                    wbad_next  = (num_v == '0) || ({1'b0, num_v} > DIM_MAX);
                    phase_next = PH_HEIGHT;
                end
                PH_HEIGHT: begin
                    height_next = DW'(num_v);
                    if (wbad_reg || num_v == '0 || {1'b0, num_v} > DIM_MAX) begin
                        do_err = 1'b1; err_code = ERR_HEADER;
                    end else if (fmt_reg == FMT_P1 || fmt_reg == FMT_P4) begin
                        maxs_next = 16'd1;
                        do_hdr    = 1'b1;
                    end else begin
                        phase_next = PH_MAXVAL;
                    end
                end
                PH_MAXVAL: begin
                    if (fmt_reg == FMT_P2 || fmt_reg == FMT_P3) begin
                        if (num_v == '0 || num_v > ACC_W'(MAXV_16)) begin
                            do_err = 1'b1; err_code = ERR_HEADER;
                        end
                    end else if (num_v != ACC_W'(MAXV_8) && num_v != ACC_W'(MAXV_16)) begin
                        do_err = 1'b1; err_code = ERR_HEADER;
                    end
                    if (!do_err) begin
                        maxs_next = num_v[15:0];
                        do_hdr    = 1'b1;
                    end
                end
                default: begin
                    divv_next     = num_v;
                    status.go_div = 1'b1;
                end
            endcase
        end

        // value*255/maxval: quotient is 8 bits unless saturated
        if (cmd.div_mul) begin
            divd_next = {divv_reg, 8'b0} - {8'b0, divv_reg};
        end
        if (cmd.div_cmp) begin
            dsat_next = divd_reg >= {8'b0, maxs_reg, 8'b0};
            divr_next = divd_reg[23:8];
            divk_next = 3'd7;
            divq_next = '0;
        end
        if (cmd.div_iter) begin
            if (trial >= {1'b0, maxs_reg}) begin
                divr_next = 16'(trial - {1'b0, maxs_reg});
                divq_next[divk_reg] = 1'b1;
            end else begin
                divr_next = trial[15:0];
            end
            divk_next = divk_reg - 3'd1;
        end
        if (cmd.div_done) begin
            eofp_next = 1'b0;
            comp_v    = {8'b0, sval};
            if (fmt_reg == FMT_P2) begin
                do_pix = 1'b1; pr = comp_v; pg = comp_v; pb = comp_v;
            end else begin
                do_comp = 1'b1;
            end
        end
        if (cmd.eof_err) begin
            do_err = 1'b1; err_code = ERR_SHORT;
        end
        if (cmd.bit_emit) begin
            do_pix = 1'b1;
            pr = {15'b0, c[3'd7 - bitk_reg]}; pg = pr; pb = pr;
            bitk_next = bitk_reg + 3'd1;
        end

        if (do_comp) begin
            unique case (comp_reg)
                2'd0: begin hred_next = comp_v; comp_next = 2'd1; end
                2'd1: begin hgrn_next = comp_v; comp_next = 2'd2; end
                default: begin
                    comp_next = 2'd0;
                    do_pix = 1'b1; pr = hred_reg; pg = hgrn_reg; pb = comp_v;
                end
            endcase
        end

        if (do_err || do_hdr || do_pix) begin
            ovld_next = 1'b1; ofmt_next = fmt_reg;
            ow_next = '0; oh_next = '0; om_next = '0;
            or_next = '0; og_next = '0; ob_next = '0;
            oerr_next = ERR_NONE; olast_next = 1'b0;
        end
        if (do_err) begin
            phase_next = PH_HALT;
            okind_next = KIND_ERROR; oerr_next = err_code; olast_next = 1'b1;
        end else if (do_hdr) begin
            phase_next = PH_PIXELS; col_next = '0; row_next = '0;
            okind_next = KIND_HEADER;
            ow_next = 16'(width_reg); oh_next = 16'(height_next); om_next = maxs_next;
        end else if (do_pix) begin
            okind_next = KIND_PIXEL;
            or_next = pr; og_next = pg; ob_next = pb; olast_next = fin;
            if (col_inc >= {1'b0, width_reg}) begin
                col_next = '0;
                row_next = row_inc[DW-1:0];
            end else begin
                col_next = col_inc[DW-1:0];
            end
            if (fin) begin
                phase_next = PH_HALT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_MAGIC0; fmt_reg <= '0; width_reg <= '0; wbad_reg <= 1'b0;
            height_reg <= '0; maxs_reg <= '0; col_reg <= '0; row_reg <= '0;
            acc_reg <= '0; innum_reg <= 1'b0; incom_reg <= 1'b0; comp_reg <= '0;
            hred_reg <= '0; hgrn_reg <= '0; hhi_reg <= '0; bph_reg <= 1'b0;
            eofp_reg <= 1'b0; bitk_reg <= '0; divk_reg <= '0; ovld_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next; fmt_reg <= fmt_next; width_reg <= width_next;
            wbad_reg <= wbad_next; height_reg <= height_next; maxs_reg <= maxs_next;
            col_reg <= col_next; row_reg <= row_next; acc_reg <= acc_next;
            innum_reg <= innum_next; incom_reg <= incom_next; comp_reg <= comp_next;
            hred_reg <= hred_next; hgrn_reg <= hgrn_next; hhi_reg <= hhi_next;
            bph_reg <= bph_next; eofp_reg <= eofp_next; bitk_reg <= bitk_next;
            divk_reg <= divk_next; ovld_reg <= ovld_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg <= act_next; byte_reg <= byte_next;
        divv_reg <= divv_next; divd_reg <= divd_next; divr_reg <= divr_next;
        divq_reg <= divq_next; dsat_reg <= dsat_next;
        okind_reg <= okind_next; ofmt_reg <= ofmt_next; ow_reg <= ow_next;
        oh_reg <= oh_next; om_reg <= om_next; or_reg <= or_next; og_reg <= og_next;
        ob_reg <= ob_next; oerr_reg <= oerr_next; olast_reg <= olast_next;
    end

    assign m_tvalid = ovld_reg;
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {3'b0, oerr_reg, ob_reg, og_reg, or_reg, om_reg, oh_reg, ow_reg, ofmt_reg};

endmodule

// ----- rtl/netpbm_stream_decoder.sv -----
// A byte is accepted, then executed into the output register. An ASCII sample that
// completes on a P2/P3 byte then goes through the serial divider by maxval: a
// multiply, a compare and 8 quotient steps, then a finish. A new byte is taken only
// when the last is done; a P4 byte gives up to 8 pixel beats, one a cycle while the
// output is free. Output stalls hold execution. Synchronous active-low aresetn (and
// the restart action) return the parser to waiting for the first magic byte.
module netpbm_stream_decoder #(
    parameter int DIM_BITS = nsd_pkg::DIM_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nsd_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  logic [nsd_pkg::S_TUSER_W-1:0] s_tuser,  // [1:0] action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] format, [18:3] width, [34:19] height, [50:35] maxval, [66:51] red,
    // [82:67] green, [98:83] blue, [100:99] error_code, [103:101] zero
    output logic [nsd_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [nsd_pkg::M_TUSER_W-1:0] m_tuser,  // [1:0] kind
    output logic                          m_tlast
);
    import nsd_pkg::*;

    nsd_cmd_t    cmd;
    nsd_status_t status;

    nsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nsd_datapath #(
        .DIM_BITS (DIM_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

// ----- rtl/nsd_checker.sv -----
module nsd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [nsd_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [nsd_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [nsd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [nsd_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                          m_tlast
);
    import nsd_pkg::*;

    // nothing is presented in the cycle after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // an offered input beat waits unchanged until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("waiting input beat changed");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled beat changed");

    // error beats close the stream and carry only the format and a code
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ERROR |-> m_tlast && m_tdata[98:3] == '0
            && m_tdata[100:99] != ERR_NONE)
        else $error("malformed error beat");

    a_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_HEADER |-> !m_tlast && m_tdata[66:51] == '0
            && m_tdata[18:3] != '0 && m_tdata[50:35] != '0)
        else $error("malformed header beat");

endmodule

bind netpbm_stream_decoder nsd_checker u_nsd_checker (.*);
